/* design/ncm_pkg.sv */
package ncm_pkg;

    localparam int CFG_W      = 11;
    localparam logic [CFG_W-1:0] FACE_SIZE_RST = 11'd256;
    localparam int QW         = 33;    // quotient d^2 * 2^32 / sum, at most 2^32
    localparam int XW         = 34;    // quotient padded to whole digit pairs
    localparam int ROOT_W     = 17;    // root at most 65536
    localparam int REM_W      = 19;
    localparam int DIV_STEPS  = QW;
    localparam int SQRT_STEPS = XW / 2;

    // per-face direction tables, entries -1, 0 or +1, faces six and seven all zero
    localparam logic signed [1:0] AXIS_TAB [8][3] = '{
        '{2'sd1, 2'sd0, 2'sd0}, '{-2'sd1, 2'sd0, 2'sd0},
        '{2'sd0, 2'sd1, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0},
        '{2'sd0, 2'sd0, 2'sd1}, '{2'sd0, 2'sd0, -2'sd1},
        '{2'sd0, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, 2'sd0}
    };
    localparam logic signed [1:0] S_TAB [8][3] = '{
        '{2'sd0, 2'sd0, -2'sd1}, '{2'sd0, 2'sd0, 2'sd1},
        '{2'sd1, 2'sd0, 2'sd0}, '{2'sd1, 2'sd0, 2'sd0},
        '{2'sd1, 2'sd0, 2'sd0}, '{-2'sd1, 2'sd0, 2'sd0},
        '{2'sd0, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, 2'sd0}
    };
    localparam logic signed [1:0] T_TAB [8][3] = '{
        '{2'sd0, -2'sd1, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0},
        '{2'sd0, 2'sd0, 2'sd1}, '{2'sd0, 2'sd0, -2'sd1},
        '{2'sd0, -2'sd1, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0},
        '{2'sd0, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, 2'sd0}
    };

    typedef struct packed {
        logic       vld;
        logic       zero;
        logic [2:0] neg;
    } t_ctl;

endpackage

/* design/normalization_cubemap_texel_top.sv */
// channel | direction | tdata fields (low bit up)
// s_axis  | in        | face [2:0], u_coord [12:3], v_coord [22:13]
// m_axis  | out       | red [7:0], green [15:8], blue [23:16]
// cfg     | in        | face_size [10:0], written when i_cfg_we is high
//
// one texel per clock sustained while output words are taken; from accept to output word
// a texel passes 2 front stages, 33 divider cells, 17 square root cells, output register
// the whole pipe advances together; it stalls only while the output word waits
// synchronous active-low reset clears the valid line and sets face_size to 256
module normalization_cubemap_texel_top #(
    parameter int MAX_FACE_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // face, u_coord, v_coord
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // red, green, blue
    input  logic        i_cfg_we,
    input  logic [ncm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import ncm_pkg::*;

    // magnitude width of a direction component
    localparam int MW   = ($clog2(MAX_FACE_SIZE) + 1 > 11) ? $clog2(MAX_FACE_SIZE) + 1 : 11;
    localparam int SW   = 2 * MW + 2;
    localparam int MAXC = (MAX_FACE_SIZE > 2047) ? 2047 : MAX_FACE_SIZE;
    localparam int L    = 2 + DIV_STEPS + SQRT_STEPS;

    logic [CFG_W-1:0] r_face_size;
    logic [CFG_W-1:0] w_size_c;
    logic             w_en;
    t_ctl             r_ctl [L];
    logic             r_out_valid;
    logic [23:0]      r_out_data;
    logic [23:0]      n_out_data;

    logic [2*MW-1:0]  w_sq [3];
    logic [SW-1:0]    w_sum;
    logic [2:0]       w_neg;
    logic             w_zero;

    logic [SW:0]      w_dr [DIV_STEPS+1][3];
    logic [SW-1:0]    w_dd [DIV_STEPS+1][3];
    logic [QW-1:0]    w_dq [DIV_STEPS+1][3];
    logic [XW-1:0]    w_sx [SQRT_STEPS+1][3];
    logic [ROOT_W-1:0] w_sr [SQRT_STEPS+1][3];
    logic [REM_W-1:0] w_sm [SQRT_STEPS+1][3];

    // whole pipe moves unless a finished word is held
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= FACE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_face_size <= i_cfg_wdata;
        end
    end

    // face size limited to 2..max
    always_comb begin
        if (r_face_size < CFG_W'(2)) begin
            w_size_c = CFG_W'(2);
        end else if (r_face_size > CFG_W'(MAXC)) begin
            w_size_c = CFG_W'(MAXC);
        end else begin
            w_size_c = r_face_size;
        end
    end

    ncm_front #(.MW(MW)) u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_face (i_s_axis_tdata[2:0]),
        .i_u    (i_s_axis_tdata[12:3]),
        .i_v    (i_s_axis_tdata[22:13]),
        .i_size (MW'(w_size_c)),
        .o_sq   (w_sq),
        .o_sum  (w_sum),
        .o_neg  (w_neg),
        .o_zero (w_zero)
    );

    // divider chain: q = d^2 * 2^32 / sum, one quotient bit per cell
    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign w_dr[0][k] = (SW+1)'(w_sq[k]);
        assign w_dd[0][k] = w_sum;
        assign w_dq[0][k] = '0;
        for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
            ncm_div_cell #(.SW(SW)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_rem (w_dr[i][k]),
                .i_den (w_dd[i][k]),
                .i_quo (w_dq[i][k]),
                .o_rem (w_dr[i+1][k]),
                .o_den (w_dd[i+1][k]),
                .o_quo (w_dq[i+1][k])
            );
        end
        // square root chain, two radicand bits per cell
        assign w_sx[0][k] = XW'(w_dq[DIV_STEPS][k]);
        assign w_sr[0][k] = '0;
        assign w_sm[0][k] = '0;
        for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
            ncm_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    (w_sx[i][k]),
                .i_root (w_sr[i][k]),
                .i_rem  (w_sm[i][k]),
                .o_x    (w_sx[i+1][k]),
                .o_root (w_sr[i+1][k]),
                .o_rem  (w_sm[i+1][k])
            );
        end
    end

    // valid, sign and zero flags travel beside the cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) begin
                r_ctl[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_ctl[0] <= '{vld: i_s_axis_tvalid, zero: 1'b0, neg: 3'b000};
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= '{vld: r_ctl[1].vld, zero: w_zero, neg: w_neg};
            for (int i = 3; i < L; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
            r_out_valid <= r_ctl[L-1].vld;
        end
    end

    // byte = floor((n + 65536) * 255 / 2^17), limited to 255
    always_comb begin
        logic signed [18:0] nv;
        logic [18:0]        xv;
        logic [26:0]        pv;
        logic [9:0]         ev;
        n_out_data = '0;
        for (int k = 0; k < 3; k++) begin
            nv = r_ctl[L-1].zero ? 19'sd0 : $signed(19'(w_sr[SQRT_STEPS][k]));
            if (r_ctl[L-1].neg[k]) begin
                nv = -nv;
            end
            xv = 19'(nv + 19'sd65536);
            pv = {xv, 8'b0} - 27'(xv);
            ev = pv[26:17];
            n_out_data[8*k +: 8] = (ev > 10'd255) ? 8'd255 : ev[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_face_size == FACE_SIZE_RST)
        else $error("face_size not restored by reset");

    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_ctl[L-1].vld && r_ctl[L-1].zero |=> o_m_axis_tdata == {3{8'd127}})
        else $error("zero direction did not encode to mid scale");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[L-1].vld && !r_ctl[L-1].zero |->
            w_sr[SQRT_STEPS][0] <= 17'd65536 && w_sr[SQRT_STEPS][1] <= 17'd65536
            && w_sr[SQRT_STEPS][2] <= 17'd65536)
        else $error("normalized component above one");
`endif

endmodule

/* design/ncm_front.sv */
module ncm_front #(
    parameter int MW = 11
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [2:0]          i_face,
    input  logic [9:0]          i_u,
    input  logic [9:0]          i_v,
    input  logic [MW-1:0]       i_size,
    output logic [2*MW-1:0]     o_sq [3],
    output logic [2*MW+1:0]     o_sum,
    output logic [2:0]          o_neg,
    output logic                o_zero
);
    import ncm_pkg::*;

    localparam int DW = MW + 1;
    localparam int SW = 2 * MW + 2;

    logic signed [DW-1:0] w_su, w_sv, w_nm1;
    logic signed [DW-1:0] n_d [3];
    logic signed [DW-1:0] r_d [3];
    logic [MW-1:0]        w_mag [3];
    logic [2*MW-1:0]      n_sq [3];
    logic [SW-1:0]        n_sum;

    function automatic logic signed [DW-1:0] sel(input logic signed [1:0] c,
                                                 input logic signed [DW-1:0] x);
        logic signed [DW-1:0] y;
        y = '0;
        if (c == 2'sd1) begin
            y = x;
        end else if (c == -2'sd1) begin
            y = -x;
        end
        return y;
    endfunction

    always_comb begin
        w_nm1 = $signed(DW'(i_size)) - DW'(1);
        w_su  = $signed(DW'({i_u, 1'b0})) - w_nm1;
        w_sv  = $signed(DW'({i_v, 1'b0})) - w_nm1;
        for (int k = 0; k < 3; k++) begin
            n_d[k] = sel(AXIS_TAB[i_face][k], w_nm1) + sel(S_TAB[i_face][k], w_su)
                   + sel(T_TAB[i_face][k], w_sv);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_d[k][DW-1] ? MW'(-r_d[k]) : MW'(r_d[k]);
            n_sq[k]  = w_mag[k] * w_mag[k];
            n_sum    = n_sum + SW'(n_sq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k]  <= n_d[k];
                o_sq[k] <= n_sq[k];
                o_neg[k] <= r_d[k][DW-1];
            end
            o_sum  <= n_sum;
            o_zero <= (n_sum == '0);
        end
    end

endmodule

/* design/ncm_div_cell.sv */
module ncm_div_cell #(
    parameter int SW = 24
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SW:0]        i_rem,
    input  logic [SW-1:0]      i_den,
    input  logic [ncm_pkg::QW-1:0] i_quo,
    output logic [SW:0]        o_rem,
    output logic [SW-1:0]      o_den,
    output logic [ncm_pkg::QW-1:0] o_quo
);
    import ncm_pkg::*;

    logic          w_ge;
    logic [SW:0]   w_diff;

    // one restoring step: subtract if it fits, then double the remainder
    always_comb begin
        w_ge   = (i_rem >= {1'b0, i_den});
        w_diff = w_ge ? (i_rem - {1'b0, i_den}) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= {w_diff[SW-1:0], 1'b0};
            o_den <= i_den;
            o_quo <= {i_quo[QW-2:0], w_ge};
        end
    end

endmodule

/* design/ncm_sqrt_cell.sv */
module ncm_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ncm_pkg::XW-1:0]      i_x,
    input  logic [ncm_pkg::ROOT_W-1:0]  i_root,
    input  logic [ncm_pkg::REM_W-1:0]   i_rem,
    output logic [ncm_pkg::XW-1:0]      o_x,
    output logic [ncm_pkg::ROOT_W-1:0]  o_root,
    output logic [ncm_pkg::REM_W-1:0]   o_rem
);
    import ncm_pkg::*;

    localparam int TW = REM_W + 2;

    logic [TW-1:0] w_sh, w_trial, w_diff;
    logic          w_ge;

    // one digit pair of the integer square root
    always_comb begin
        w_sh    = {i_rem, i_x[XW-1:XW-2]};
        w_trial = TW'({i_root, 2'b01});
        w_ge    = (w_sh >= w_trial);
        w_diff  = w_ge ? (w_sh - w_trial) : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= {i_x[XW-3:0], 2'b00};
            o_root <= {i_root[ROOT_W-2:0], w_ge};
            o_rem  <= w_diff[REM_W-1:0];
        end
    end

endmodule

/* bench/normalization_cubemap_texel_top_tb.sv */
module normalization_cubemap_texel_top_tb;

    import ncm_pkg::*;

    localparam int MAX_FS    = 1024;
    localparam int PIPE_LAT  = 53;

    // face codes
    typedef enum logic [2:0] {
        FACE_PX = 3'd0, FACE_NX = 3'd1, FACE_PY = 3'd2, FACE_NY = 3'd3,
        FACE_PZ = 3'd4, FACE_NZ = 3'd5, FACE_X6 = 3'd6, FACE_X7 = 3'd7
    } t_face;

    typedef struct packed {
        logic [9:0] v_coord;
        logic [9:0] u_coord;
        logic [2:0] face;
    } t_texel;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // directed row: texel, whether an expected color is typed in, and that color
    typedef struct {
        t_texel texel;
        bit     has_rgb;
        t_rgb   rgb;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // face, u_coord, v_coord
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // red, green, blue
    logic        i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    normalization_cubemap_texel_top #(.MAX_FACE_SIZE(MAX_FS)) dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of the face size register
    logic [CFG_W-1:0] face_size_q = FACE_SIZE_RST;

    t_rgb   rgb_queue[$];
    int     errors = 0;
    bit     hold_off = 0;     // long receiver stall requested
    bit     rx_quiet = 0;     // receiver never stalls
    bit     tx_quiet = 0;

    // bitwise integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] to_byte(longint d, longint unsigned sumsq);
        longint          n;
        longint unsigned mag, e;
        n = 0;
        if (sumsq != 0) begin
            mag = (d < 0) ? -d : d;
            n = longint'(root_floor(((mag * mag) << 32) / sumsq));
            if (d < 0) n = -n;
        end
        e = (unsigned'(n + 65536) * 255) >> 17;
        if (e > 255) e = 255;
        return e[7:0];
    endfunction

    // face table lookup, entries -1/0/+1
    function automatic int axis_of(int f, int k);
        if (f >= 6) return 0;
        if (k == f / 2) return (f % 2) ? -1 : 1;
        return 0;
    endfunction

    function automatic int s_of(int f, int k);
        case (f)
            0: return (k == 2) ? -1 : 0;
            1: return (k == 2) ? 1 : 0;
            2, 3, 4: return (k == 0) ? 1 : 0;
            5: return (k == 0) ? -1 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic int t_of(int f, int k);
        case (f)
            2: return (k == 2) ? 1 : 0;
            3: return (k == 2) ? -1 : 0;
            6, 7: return 0;
            default: return (k == 1) ? -1 : 0;
        endcase
    endfunction

    function automatic t_rgb texel_color(t_texel tx, logic [CFG_W-1:0] fs);
        longint          n, su, sv;
        longint          d[3];
        longint unsigned sumsq;
        logic [7:0]      b[3];
        int              f;
        n = fs;
        if (n < 2) n = 2;
        if (n > MAX_FS) n = MAX_FS;
        f = tx.face;
        su = 2 * longint'(tx.u_coord) - n + 1;
        sv = 2 * longint'(tx.v_coord) - n + 1;
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = axis_of(f, k) * (n - 1) + su * s_of(f, k) + sv * t_of(f, k);
            sumsq += d[k] * d[k];
        end
        for (int k = 0; k < 3; k++) b[k] = to_byte(d[k], sumsq);
        return '{blue: b[2], green: b[1], red: b[0]};
    endfunction

    // send one texel after a random gap (none while tx_quiet), queue its color once accepted
    task automatic send_texel(t_texel tx, bit typed, t_rgb want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, tx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        rgb_queue.push_back(typed ? want : texel_color(tx, face_size_q));
    endtask

    task automatic send_idle();
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_face_size(logic [CFG_W-1:0] fs);
        send_idle();
        wait (rgb_queue.size() == 0);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fs;
        face_size_q = fs;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_texel rand_texel(int fs_lim);
        t_texel tx;
        int r;
        r = $urandom_range(0, 99);
        tx.face = (r < 4) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        if (r >= 90 || fs_lim < 1) begin
            // beyond the face edge, full field range
            tx.u_coord = 10'($urandom);
            tx.v_coord = 10'($urandom);
        end else begin
            tx.u_coord = 10'($urandom_range(0, fs_lim - 1));
            tx.v_coord = 10'($urandom_range(0, fs_lim - 1));
        end
        return tx;
    endfunction

    // receiver: random stalls (none while rx_quiet), or a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_quiet) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 8) == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    // checker: every accepted word against the oldest expected color
    always @(posedge i_clk) begin
        t_rgb want, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (rgb_queue.size() == 0) begin
                $display("%0t unexpected word %h", $time, got);
                errors++;
            end else begin
                want = rgb_queue.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t red expected %0d actual %0d", $time, want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green) begin
                    $display("%0t green expected %0d actual %0d", $time, want.green,
                             got.green);
                    errors++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t blue expected %0d actual %0d", $time, want.blue,
                             got.blue);
                    errors++;
                end
            end
        end
    end

    // long receiver stall counted in its own process
    task automatic long_stall();
        hold_off = 1;
        repeat (300) @(posedge i_clk);
        hold_off = 0;
    endtask

    t_row rows[$];

    initial begin
        int lim;
        logic [CFG_W-1:0] sizes[$];
        // directed: extremes, every face, zero direction, corners
        // face centers at odd size are exact axis directions
        rows = '{
            '{'{v_coord: 10'd0, u_coord: 10'd0, face: FACE_PX}, 0, '0},
            '{'{v_coord: 10'd255, u_coord: 10'd255, face: FACE_PX}, 0, '0},
            '{'{v_coord: 10'd0, u_coord: 10'd255, face: FACE_NX}, 0, '0},
            '{'{v_coord: 10'd255, u_coord: 10'd0, face: FACE_PY}, 0, '0},
            '{'{v_coord: 10'd128, u_coord: 10'd127, face: FACE_NY}, 0, '0},
            '{'{v_coord: 10'd77, u_coord: 10'd200, face: FACE_PZ}, 0, '0},
            '{'{v_coord: 10'd1023, u_coord: 10'd1023, face: FACE_NZ}, 0, '0},
            '{'{v_coord: 10'd1023, u_coord: 10'd0, face: FACE_X6},
              1, '{blue: 8'd127, green: 8'd127, red: 8'd127}},
            '{'{v_coord: 10'd0, u_coord: 10'd1023, face: FACE_X7},
              1, '{blue: 8'd127, green: 8'd127, red: 8'd127}},
            '{'{v_coord: 10'd512, u_coord: 10'd512, face: FACE_PX}, 0, '0},
            '{'{v_coord: 10'd341, u_coord: 10'd682, face: FACE_NZ}, 0, '0}
        };
        tx_quiet = 1;
        rx_quiet = 1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_texel(rows[i].texel, rows[i].has_rgb, rows[i].rgb);
        tx_quiet = 0;
        rx_quiet = 0;
        foreach (rows[i]) send_texel(rows[i].texel, 0, '0);

        // odd size: center texel of +X is exactly (+1,0,0)
        write_face_size(11'd3);
        send_texel('{v_coord: 10'd1, u_coord: 10'd1, face: FACE_PX}, 1,
                   '{blue: 8'd127, green: 8'd127, red: 8'd255});
        send_texel('{v_coord: 10'd1, u_coord: 10'd1, face: FACE_NZ}, 1,
                   '{blue: 8'd0, green: 8'd127, red: 8'd127});

        // sizes including the extremes and clamped ones outside 2..1024
        sizes = '{11'd0, 11'd1, 11'd2, 11'd2047, 11'd1024, 11'd1025, 11'd7, 11'd256,
                  11'd100, 11'd513, 11'h555, 11'h2aa};
        foreach (sizes[p]) begin
            write_face_size(sizes[p]);
            lim = (sizes[p] < 2) ? 2 : (sizes[p] > MAX_FS ? MAX_FS : sizes[p]);
            for (int i = 0; i < 110; i++) begin
                if (p == 3 && i == 40) fork long_stall(); join_none
                tx_quiet = (i >= 80 && i < 95);
                rx_quiet = (i >= 60 && i < 75);
                send_texel(rand_texel(lim), 0, '0);
            end
        end
        tx_quiet = 0;
        rx_quiet = 0;
        send_idle();
        wait (rgb_queue.size() == 0 && !hold_off);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
